/* rtl/core/ngd_pkg.sv */
// ----------------------------------------------------------------------------
// Noise gate decision package
// Shared types, constants and helper functions for the gate decision core.
// ----------------------------------------------------------------------------
package ngd_pkg;

  // Width of the hold counter.
  localparam int HOLD_BITS = 16;

  // Depth of the queue between the classifier and the gate sequencer.
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  // Configuration register indexes.
  localparam logic [1:0] REG_OPEN_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_CLOSE_FACTOR   = 2'd1;
  localparam logic [1:0] REG_HOLD_LENGTH    = 2'd2;

  // Configuration reset values.
  localparam logic [15:0] OPEN_THRESHOLD_RST = 16'd65;
  localparam logic [15:0] CLOSE_FACTOR_RST   = 16'd46396;
  localparam logic [15:0] HOLD_LENGTH_RST    = 16'd7200;

  // Leak weights in Q0.16.
  localparam logic [16:0] W_TRANSIENT = 17'd62259;
  localparam logic [16:0] W_SLOW      = 17'd64881;

  // Score targets.
  localparam logic [15:0] SCORE_FULL = 16'd65535;
  localparam logic [15:0] SCORE_HALF = 16'd32768;
  localparam logic [15:0] SCORE_ZERO = 16'd0;

  // Output phase codes.
  localparam logic [2:0] GP_CLOSED  = 3'd0;
  localparam logic [2:0] GP_OPENING = 3'd1;
  localparam logic [2:0] GP_OPEN    = 3'd2;
  localparam logic [2:0] GP_HOLDING = 3'd3;
  localparam logic [2:0] GP_CLOSING = 3'd4;

  // Confidence target class decided by the front end.
  typedef enum logic [1:0] {
    CT_ZERO = 2'd0,
    CT_HALF = 2'd1,
    CT_FULL = 2'd2
  } conf_tgt_e;

  // Gate phase, one-hot.
  typedef enum logic [4:0] {
    PH_CLOSED  = 5'b00001,
    PH_OPENING = 5'b00010,
    PH_OPEN    = 5'b00100,
    PH_HOLDING = 5'b01000,
    PH_CLOSING = 5'b10000
  } phase_e;

  // One classified sample as it travels from front end to back end.
  typedef struct packed {
    logic                 trans_hit;   // large sample-to-sample jump
    logic                 sus_hit;     // magnitude close to follower level
    conf_tgt_e            conf_tgt;    // confidence target class
    logic                 gain_full;   // gain at or above 0.99
    logic                 gain_low;    // gain at or below 1/100
    logic [22:0]          rms100;      // rms level times 100
    logic [15:0]          thr;         // open threshold
    logic [31:0]          thr_cf;      // threshold times close factor
    logic [HOLD_BITS-1:0] hold_load;   // saturated hold length
  } ngd_item_t;

  // Leaky score update: (s*w + f*(1-w) + 0.5) in Q0.16.  The sum never
  // exceeds 65535 after the shift, so no saturation is needed.
  function automatic logic [15:0] leak(input logic [15:0] s, input logic [16:0] w,
                                       input logic [15:0] f);
    logic [31:0] acc;
    acc = 32'(s) * 32'(w) + 32'(f) * 32'(17'h10000 - w) + 32'd32768;
    return acc[31:16];
  endfunction

  // Score value for a confidence target class.
  function automatic logic [15:0] conf_value(input conf_tgt_e t);
    logic [15:0] v;
    case (t)
      CT_FULL: v = SCORE_FULL;
      CT_HALF: v = SCORE_HALF;
      default: v = SCORE_ZERO;
    endcase
    return v;
  endfunction

endpackage

/* rtl/core/ngd_front.sv */
// ----------------------------------------------------------------------------
// Noise gate front end
// Accepts samples, classifies them against the detector thresholds and holds
// the classified beat until the queue takes it.
// ----------------------------------------------------------------------------
module ngd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic signed [15:0]  sample_in_i,
  input  logic signed [15:0]  previous_sample_i,
  input  logic [15:0]         follower_level_i,
  input  logic [15:0]         rms_level_i,
  input  logic [16:0]         gain_now_i,
  input  logic [15:0]         open_threshold_i,
  input  logic [15:0]         close_factor_i,
  input  logic [15:0]         hold_length_i,
  output logic                item_valid_o,
  output ngd_pkg::ngd_item_t  item_o,
  input  logic                queue_full_i
);
  import ngd_pkg::*;

  logic               valid_q, valid_d;
  ngd_item_t          item_q, item_d;
  logic               accept;
  logic               advance;
  logic signed [16:0] diff;
  logic [15:0]        jump;
  logic [15:0]        mag;
  logic [15:0]        dev;
  logic [31:0]        rms_scaled;
  logic [31:0]        thr_hi;
  logic [31:0]        thr_lo;
  logic [23:0]        gain100;

  // The holding stage moves on whenever the queue has room.
  assign advance      = !valid_q || !queue_full_i;
  assign full         = !advance;
  assign accept       = push && advance;
  assign item_valid_o = valid_q;
  assign item_o       = item_q;

  // Classification of the incoming sample.
  always_comb begin
    diff       = 17'(sample_in_i) - 17'(previous_sample_i);
    jump       = diff[16] ? 16'(-diff) : diff[15:0];
    mag        = sample_in_i[15] ? 16'(-17'(sample_in_i)) : sample_in_i[15:0];
    dev        = (follower_level_i > mag) ? (follower_level_i - mag)
                                          : (mag - follower_level_i);
    // Ratio test rms/(thr + 1e-5) against 1.2 and 0.8, scaled to integers.
    rms_scaled = 32'(rms_level_i) * 32'd15625;
    thr_hi     = 32'(open_threshold_i) * 32'd18750 + 32'd6144;
    thr_lo     = 32'(open_threshold_i) * 32'd12500 + 32'd4096;
    gain100    = 24'(gain_now_i) * 24'd100;

    item_d.trans_hit = (20'(jump) * 20'd10) > 20'd32768;
    item_d.sus_hit   = (19'(dev) * 19'd5) < 19'd32768;
    if (rms_scaled > thr_hi) begin
      item_d.conf_tgt = CT_FULL;
    end else if (rms_scaled < thr_lo) begin
      item_d.conf_tgt = CT_ZERO;
    end else begin
      item_d.conf_tgt = CT_HALF;
    end
    item_d.gain_full = gain100 >= 24'd6488064;
    item_d.gain_low  = gain100 <= 24'd65536;
    item_d.rms100    = 23'(rms_level_i) * 23'd100;
    item_d.thr       = open_threshold_i;
    item_d.thr_cf    = 32'(open_threshold_i) * 32'(close_factor_i);
    if (32'(hold_length_i) > 32'((64'd1 << HOLD_BITS) - 64'd1)) begin
      item_d.hold_load = '1;
    end else begin
      item_d.hold_load = HOLD_BITS'(hold_length_i);
    end
  end

  // Valid flag of the holding stage.
  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (valid_q && !queue_full_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, loaded on each accepted beat.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_d;
    end
  end

endmodule

/* rtl/core/ngd_fifo.sv */
// ----------------------------------------------------------------------------
// Noise gate decoupling queue
// Short first-in first-out queue of classified beats between the front end
// and the gate sequencer.
// ----------------------------------------------------------------------------
module ngd_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  ngd_pkg::ngd_item_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output ngd_pkg::ngd_item_t data_o,
  output logic               valid_o
);
  import ngd_pkg::*;

  ngd_item_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0]   count_q, count_d;
  logic                    do_push;
  logic                    do_pop;

  assign full_o  = count_q == FIFO_CNT_W'(FIFO_DEPTH);
  assign valid_o = count_q != '0;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue fill count beyond depth");
`endif

endmodule

/* rtl/core/ngd_back.sv */
// ----------------------------------------------------------------------------
// Noise gate sequencer
// Updates the leaky scores, forms the adaptive threshold and steps the
// five-phase gate with its hold counter; results go to an output register.
// ----------------------------------------------------------------------------
module ngd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  ngd_pkg::ngd_item_t item_i,
  output logic               item_pop_o,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         gate_phase_o,
  output logic               target_open_o,
  output logic [15:0]        confidence_out_o
);
  import ngd_pkg::*;

  phase_e               phase_q, phase_d;
  logic                 target_q, target_d;
  logic [HOLD_BITS-1:0] hold_q, hold_d;
  logic [15:0]          conf_q, conf_d;
  logic [15:0]          trans_q, trans_d;
  logic [15:0]          sus_q, sus_d;
  logic                 out_valid_q, out_valid_d;
  logic [2:0]           out_phase_q;
  logic                 out_target_q;
  logic [15:0]          out_conf_q;
  logic                 step;
  logic                 trans_high;
  logic                 sustain_conf;
  logic [22:0]          athr;
  logic [39:0]          close_ref;
  logic [39:0]          rms_wide;
  logic                 above;
  logic                 below_close;
  logic                 c_gt3;
  logic                 c_lt3;
  logic                 c_gt4;
  logic                 c_gt7;
  logic                 c_lt5;
  logic [2:0]           phase_code;

  // A sample is processed when the output register is free or being drained.
  assign step       = item_valid_i && (!out_valid_q || pop);
  assign item_pop_o = step;
  assign empty      = !out_valid_q;

  // Score updates.
  always_comb begin
    trans_d = leak(trans_q, W_TRANSIENT, item_i.trans_hit ? SCORE_FULL : SCORE_ZERO);
    sus_d   = leak(sus_q, W_SLOW, item_i.sus_hit ? SCORE_FULL : SCORE_ZERO);
    conf_d  = leak(conf_q, W_SLOW, conf_value(item_i.conf_tgt));
  end

  // Adaptive threshold: x0.8 on a transient, x1.1 on a confident sustain, x0.88 on both.
  always_comb begin
    trans_high   = (20'(trans_d) * 20'd10) > 20'd458752;
    sustain_conf = ((20'(sus_d) * 20'd10) > 20'd458752)
                && ((20'(conf_d) * 20'd10) > 20'd524288);
    c_gt3        = (20'(conf_d) * 20'd10) > 20'd196608;
    c_lt3        = (20'(conf_d) * 20'd10) < 20'd196608;
    c_gt4        = (20'(conf_d) * 20'd10) > 20'd262144;
    c_gt7        = (20'(conf_d) * 20'd10) > 20'd458752;
    c_lt5        = (17'(conf_d) * 17'd2) < 17'd65536;
    rms_wide     = 40'({item_i.rms100, 16'd0});
    case ({trans_high, sustain_conf})
      2'b10: begin
        athr      = 23'(item_i.thr) * 23'd80;
        close_ref = 40'(item_i.thr_cf) * 40'd80;
      end
      2'b11: begin
        athr      = 23'(item_i.thr) * 23'd88;
        close_ref = 40'(item_i.thr_cf) * 40'd88;
      end
      2'b01: begin
        athr      = 23'(item_i.thr) * 23'd110;
        close_ref = 40'(item_i.thr_cf) * 40'd110;
      end
      default: begin
        athr      = 23'(item_i.thr) * 23'd100;
        close_ref = 40'(item_i.thr_cf) * 40'd100;
      end
    endcase
    above       = item_i.rms100 > athr;
    below_close = rms_wide < close_ref;
  end

  // Gate phase transitions.
  always_comb begin
    phase_d  = phase_q;
    target_d = target_q;
    hold_d   = hold_q;
    case (phase_q)
      PH_CLOSED: begin
        if (above && c_gt3) begin
          phase_d  = PH_OPENING;
          target_d = 1'b1;
        end
      end
      PH_OPENING: begin
        if (item_i.gain_full) begin
          phase_d = PH_OPEN;
          hold_d  = item_i.hold_load;
        end else if (below_close && c_lt3) begin
          phase_d  = PH_CLOSING;
          target_d = 1'b0;
        end
      end
      PH_OPEN: begin
        if (below_close && c_lt5) begin
          phase_d = PH_HOLDING;
        end
      end
      PH_HOLDING: begin
        if (hold_q != '0) begin
          hold_d = hold_q - 1'b1;
          if (above || c_gt7) begin
            phase_d = PH_OPEN;
            hold_d  = item_i.hold_load;
          end
        end else begin
          phase_d  = PH_CLOSING;
          target_d = 1'b0;
        end
      end
      PH_CLOSING: begin
        if (item_i.gain_low) begin
          phase_d = PH_CLOSED;
        end else if (above && c_gt4) begin
          phase_d  = PH_OPENING;
          target_d = 1'b1;
        end
      end
      default: begin
        phase_d  = PH_CLOSED;
        target_d = 1'b0;
      end
    endcase
  end

  // Output phase code.
  always_comb begin
    case (phase_d)
      PH_OPENING: phase_code = GP_OPENING;
      PH_OPEN:    phase_code = GP_OPEN;
      PH_HOLDING: phase_code = GP_HOLDING;
      PH_CLOSING: phase_code = GP_CLOSING;
      default:    phase_code = GP_CLOSED;
    endcase
  end

  // Output register valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_CLOSED;
      target_q    <= 1'b0;
      hold_q      <= '0;
      conf_q      <= '0;
      trans_q     <= '0;
      sus_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (step) begin
        phase_q  <= phase_d;
        target_q <= target_d;
        hold_q   <= hold_d;
        conf_q   <= conf_d;
        trans_q  <= trans_d;
        sus_q    <= sus_d;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    if (step) begin
      out_phase_q  <= phase_code;
      out_target_q <= target_d;
      out_conf_q   <= conf_d;
    end
  end

  assign gate_phase_o     = out_phase_q;
  assign target_open_o    = out_target_q;
  assign confidence_out_o = out_conf_q;

`ifndef SYNTH
  a_target_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    target_q == (phase_q == PH_OPENING || phase_q == PH_OPEN || phase_q == PH_HOLDING))
    else $error("gain target disagrees with gate phase");
  a_closed_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_CLOSED) |=> (phase_q == PH_CLOSED || phase_q == PH_OPENING))
    else $error("closed gate left for a phase other than opening");
  a_hold_expiry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && phase_q == PH_HOLDING && hold_q == '0) |=> (phase_q == PH_CLOSING))
    else $error("expired hold did not start closing");
`endif

endmodule

/* rtl/core/noise_gate_decision_logic.sv */
// ----------------------------------------------------------------------------
// Noise gate decision logic
// Per-sample gate decision with leaky detector scores, adaptive threshold,
// hysteresis and a hold counter.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter through a queue-style port: a beat is taken at a clock edge
// where push is high and full is low. Results leave the same way: while
// empty is low the oldest result sits on the result ports, and it is taken
// at an edge where pop is high. One result is produced per sample.
// Configuration registers are written through the cfg channel (index and
// data, valid and ready); ready is always high. Write them only when no
// sample is in flight.
// A sample passes the front holding register, a queue entry and the output
// register; one sample is taken every cycle while results are drained; the
// rate is set by the single sequencer score and gate update, once per cycle.
// When pop is held low, the output register, the two-entry queue and the
// front holding stage fill in turn, after which full rises; nothing is lost.
// Reset sets the gate closed with a zero gain target, clears all scores and
// the hold counter, and loads the default threshold, hysteresis factor and
// hold length.
// ----------------------------------------------------------------------------
module noise_gate_decision_logic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] sample_in_i,
  input  logic signed [15:0] previous_sample_i,
  input  logic [15:0]        follower_level_i,
  input  logic [15:0]        rms_level_i,
  input  logic [16:0]        gain_now_i,
  output logic               empty,
  input  logic               pop,
  output logic [2:0]         gate_phase_o,
  output logic               target_open_o,
  output logic [15:0]        confidence_out_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);
  import ngd_pkg::*;

  logic [15:0] open_threshold_q;
  logic [15:0] close_factor_q;
  logic [15:0] hold_length_q;
  logic        front_valid;
  ngd_item_t   front_item;
  logic        queue_full;
  logic        queue_valid;
  ngd_item_t   queue_item;
  logic        queue_pop;

  // Configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_threshold_q <= OPEN_THRESHOLD_RST;
      close_factor_q   <= CLOSE_FACTOR_RST;
      hold_length_q    <= HOLD_LENGTH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_OPEN_THRESHOLD: open_threshold_q <= cfg_data_i;
        REG_CLOSE_FACTOR:   close_factor_q   <= cfg_data_i;
        REG_HOLD_LENGTH:    hold_length_q    <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // Classifier.
  ngd_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .sample_in_i       (sample_in_i),
    .previous_sample_i (previous_sample_i),
    .follower_level_i  (follower_level_i),
    .rms_level_i       (rms_level_i),
    .gain_now_i        (gain_now_i),
    .open_threshold_i  (open_threshold_q),
    .close_factor_i    (close_factor_q),
    .hold_length_i     (hold_length_q),
    .item_valid_o      (front_valid),
    .item_o            (front_item),
    .queue_full_i      (queue_full)
  );

  // Decoupling queue.
  ngd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_valid),
    .data_i  (front_item),
    .full_o  (queue_full),
    .pop_i   (queue_pop),
    .data_o  (queue_item),
    .valid_o (queue_valid)
  );

  // Gate sequencer.
  ngd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (queue_valid),
    .item_i           (queue_item),
    .item_pop_o       (queue_pop),
    .empty            (empty),
    .pop              (pop),
    .gate_phase_o     (gate_phase_o),
    .target_open_o    (target_open_o),
    .confidence_out_o (confidence_out_o)
  );

endmodule
